>>> rtl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the ssi encoder frame reader
// Word formats, configuration record, register indexes and reset values.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // frame length limit and derived widths
  localparam int MaxPosBits = 23;
  localparam int ShiftBits  = MaxPosBits + 1;
  localparam int HalfCntW   = 6;

  // configuration register indexes
  localparam logic [2:0] RegClockMode  = 3'd0;
  localparam logic [2:0] RegHalfPeriod = 3'd1;
  localparam logic [2:0] RegTotalBits  = 3'd2;
  localparam logic [2:0] RegSingleBits = 3'd3;
  localparam logic [2:0] RegIgnoreMt   = 3'd4;

  // configuration reset values
  localparam logic [1:0]  ClockModeRst  = 2'd3;
  localparam logic [15:0] HalfPeriodRst = 16'd50;
  localparam logic [4:0]  TotalBitsRst  = 5'd17;
  localparam logic [4:0]  SingleBitsRst = 5'd17;
  localparam logic        IgnoreMtRst   = 1'b0;

  // configuration record
  typedef struct packed {
    logic [1:0]  clock_mode;
    logic [15:0] half_period_ticks;
    logic [4:0]  total_bits;
    logic [4:0]  single_turn_bits;
    logic        single_turn_only;
  } cfg_t;

  // input word
  typedef struct packed {
    logic start_req;
    logic data_in;
  } in_item_t;

  // result word
  typedef struct packed {
    logic                  clk_out;
    logic                  busy_res;
    logic                  frame_done;
    logic [MaxPosBits-1:0] position_step;
  } out_item_t;

endpackage

>>> rtl/ssi_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssi_cfg_regs: configuration register file
// Decodes the plain write port into the configuration record.
// ----------------------------------------------------------------------------
module ssi_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output ssi_pkg::cfg_t cfg
);
  import ssi_pkg::*;

  // register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_mode        <= ClockModeRst;
      cfg.half_period_ticks <= HalfPeriodRst;
      cfg.total_bits        <= TotalBitsRst;
      cfg.single_turn_bits  <= SingleBitsRst;
      cfg.single_turn_only  <= IgnoreMtRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegClockMode:  cfg.clock_mode        <= cfg_data[1:0];
        RegHalfPeriod: cfg.half_period_ticks <= cfg_data;
        RegTotalBits:  cfg.total_bits        <= cfg_data[4:0];
        RegSingleBits: cfg.single_turn_bits  <= cfg_data[4:0];
        RegIgnoreMt:   cfg.single_turn_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ssi_frame_step.sv
// ----------------------------------------------------------------------------
// ssi_frame_step: frame sequencer for one tick
// Holds the tick, half period and shift state and computes the result word
// of the current tick; state advances when fire is high.
// ----------------------------------------------------------------------------
module ssi_frame_step (
  input  logic               clk,
  input  logic               rst,
  input  ssi_pkg::cfg_t      cfg,
  input  logic               fire,
  input  ssi_pkg::in_item_t  item,
  output ssi_pkg::out_item_t result
);
  import ssi_pkg::*;

  // state
  logic [15:0]           tick_counter, tick_counter_next;
  logic [HalfCntW-1:0]   half_counter, half_counter_next;
  logic [ShiftBits-1:0]  shift_register, shift_register_next;
  logic                  running, running_next;
  logic [MaxPosBits-1:0] held_position, held_position_next;

  // per tick working values
  logic [4:0]            nbits;
  logic [15:0]           hp;
  logic                  first_level;
  logic                  sample_first;
  logic                  idle_level;
  logic                  start_now;
  logic                  active;
  logic [15:0]           tc;
  logic [HalfCntW-1:0]   hc;
  logic [ShiftBits-1:0]  sr;
  logic                  odd;
  logic                  end_half;
  logic [HalfCntW-1:0]   hc_inc;
  logic [6:0]            frame_halves;
  logic [ShiftBits-1:0]  len_mask;
  logic [MaxPosBits-1:0] st_mask;
  logic [MaxPosBits-1:0] pos;
  logic                  done;

  // mode decode and limits
  assign nbits        = (cfg.total_bits > 5'(MaxPosBits)) ? 5'(MaxPosBits) : cfg.total_bits;
  assign hp           = (cfg.half_period_ticks == 16'd0) ? 16'd1 : cfg.half_period_ticks;
  assign first_level  = ~cfg.clock_mode[1];
  assign sample_first = ~cfg.clock_mode[0];
  assign idle_level   = cfg.clock_mode[1];

  // frame start restarts counters
  assign start_now = ~running & item.start_req;
  assign active    = running | item.start_req;
  assign tc        = start_now ? 16'd0 : tick_counter;
  assign hc        = start_now ? '0 : half_counter;
  assign sr        = start_now ? '0 : shift_register;

  assign odd          = hc[0];
  assign end_half     = ({1'b0, tc} + 17'd1) >= {1'b0, hp};
  assign hc_inc       = hc + HalfCntW'(1);
  assign frame_halves = {1'b0, ({1'b0, nbits} + 6'd1)} << 1;

  // position masks
  assign len_mask = (ShiftBits'(1) << nbits) - ShiftBits'(1);
  assign st_mask  = (cfg.single_turn_bits >= 5'(MaxPosBits)) ? '1
                  : (MaxPosBits'(1) << cfg.single_turn_bits) - MaxPosBits'(1);

  // next state and result
  always_comb begin
    tick_counter_next   = tick_counter;
    half_counter_next   = half_counter;
    shift_register_next = shift_register;
    running_next        = running;
    held_position_next  = held_position;
    pos                 = '0;
    done                = 1'b0;
    result.clk_out      = idle_level;
    result.busy_res     = 1'b0;
    if (active) begin
      running_next        = 1'b1;
      half_counter_next   = hc;
      tick_counter_next   = tc;
      shift_register_next = sr;
      result.busy_res     = 1'b1;
      result.clk_out      = first_level ^ odd;
      if (end_half) begin
        tick_counter_next = 16'd0;
        if ((~odd) == sample_first) begin
          shift_register_next = {sr[ShiftBits-2:0], item.data_in};
        end
        half_counter_next = hc_inc;
        if ({1'b0, hc_inc} >= frame_halves) begin
          pos = shift_register_next[MaxPosBits-1:0] & len_mask[MaxPosBits-1:0];
          if (cfg.single_turn_only) begin
            pos = pos & st_mask;
          end
          held_position_next = pos;
          running_next       = 1'b0;
          half_counter_next  = '0;
          done               = 1'b1;
        end
      end else begin
        tick_counter_next = tc + 16'd1;
      end
    end
    result.frame_done    = done;
    result.position_step = held_position_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter   <= '0;
      half_counter   <= '0;
      shift_register <= '0;
      running        <= 1'b0;
      held_position  <= '0;
    end else if (fire) begin
      tick_counter   <= tick_counter_next;
      half_counter   <= half_counter_next;
      shift_register <= shift_register_next;
      running        <= running_next;
      held_position  <= held_position_next;
    end
  end

endmodule

>>> rtl/ssi_encoder_frame_reader_core.sv
// ----------------------------------------------------------------------------
// ssi_encoder_frame_reader_core: ssi absolute encoder master
// Input word register, frame sequencer and result word register.
// ----------------------------------------------------------------------------
// Each input word is one tick of the serial interface and yields exactly one
// result word carrying the clock line level, busy, frame done and the held
// position. All work for a word is one short pass of sequencer logic between
// the input word register and the result word register, so one word is taken
// every cycle; the input only stalls while both registers are full and the
// receiver holds off. An accepted word waits in the input word register until
// the result register is free or being drained, then moves into it with the
// sequencer state advancing alongside, and its result word can then be taken.
// A frame lasts 2*(total_bits+1) half periods of half_period_ticks words each,
// with total_bits capped at 23 and a half period of 0 counted as 1.
module ssi_encoder_frame_reader_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssi_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ssi_pkg::out_item_t out_item
);
  import ssi_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_q_valid;
  logic      step_fire;
  out_item_t step_result;

  // configuration registers
  ssi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // word moves on when the result register is free or being drained
  assign step_fire = in_q_valid & (~out_valid | out_ready);
  assign in_ready  = ~in_q_valid | step_fire;

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_item;
    end
  end

  // frame sequencer
  ssi_frame_step u_step (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (step_fire),
    .item   (in_q),
    .result (step_result)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_item <= step_result;
    end
  end

  // frame done only comes with busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.frame_done |-> out_item.busy_res)
    else $error("frame done without busy");

  // input stalls only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_q_valid && out_valid && !out_ready))
    else $error("input stalled without cause");

  // two frames never end on consecutive ticks
  a_done_spacing: assert property (@(posedge clk) disable iff (rst)
    step_fire && step_result.frame_done |=> !(step_fire && step_result.frame_done))
    else $error("frame done on consecutive ticks");

endmodule

>>> bench/ssi_frame_checker.sv
// ----------------------------------------------------------------------------
// ssi_frame_checker: result checker for the ssi encoder frame reader
// Watches the register port and both word channels. It runs its own model of
// the encoder master once per accepted input word, queues the predicted result
// words and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module ssi_frame_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  ssi_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  ssi_pkg::out_item_t out_item,
  output int                 errors,
  output int                 pending
);
  import ssi_pkg::*;

  // register copy
  cfg_t cur;

  // sequencer copy
  logic [15:0]          tick_cnt;
  logic [HalfCntW-1:0]  half_cnt;
  logic [ShiftBits-1:0] shreg;
  logic                 running;
  logic [MaxPosBits-1:0] held;
  logic                 clk_lvl;

  // predicted result words, oldest first
  out_item_t tick_results_q[$];
  out_item_t want;
  int        err_cnt = 0;

  function automatic logic [31:0] low_mask(input int n);
    if (n >= 32) return '1;
    return (32'd1 << n) - 32'd1;
  endfunction

  // advance the encoder master by one tick and return the line state
  function automatic out_item_t clock_one_tick(input in_item_t w);
    out_item_t   r;
    int          nb;
    int          hp;
    logic        first_lvl;
    logic        samp_first;
    logic        idle_lvl;
    logic        odd;
    logic [31:0] pos;
    nb         = (cur.total_bits > MaxPosBits) ? MaxPosBits : int'(cur.total_bits);
    hp         = (cur.half_period_ticks == 16'd0) ? 1 : int'(cur.half_period_ticks);
    first_lvl  = (cur.clock_mode < 2'd2);
    samp_first = (cur.clock_mode == 2'd0) || (cur.clock_mode == 2'd2);
    idle_lvl   = (cur.clock_mode >= 2'd2);
    r          = '0;
    // a start only counts while idle
    if (!running && w.start_req) begin
      running  = 1'b1;
      half_cnt = '0;
      tick_cnt = '0;
      shreg    = '0;
    end
    if (running) begin
      odd        = half_cnt[0];
      r.busy_res = 1'b1;
      clk_lvl    = odd ? !first_lvl : first_lvl;
      if (int'(tick_cnt) + 1 >= hp) begin
        tick_cnt = '0;
        // sample on the last tick of the sampling half period
        if ((odd == 1'b0) == samp_first) shreg = {shreg[ShiftBits-2:0], w.data_in};
        half_cnt = half_cnt + 1'b1;
        if (int'(half_cnt) >= 2 * (nb + 1)) begin
          pos = 32'(shreg) & low_mask(nb);
          if (cur.single_turn_only) pos = pos & low_mask(int'(cur.single_turn_bits));
          held         = pos[MaxPosBits-1:0];
          running      = 1'b0;
          half_cnt     = '0;
          r.frame_done = 1'b1;
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
      r.clk_out = clk_lvl;
      if (!running) clk_lvl = idle_lvl;
    end else begin
      clk_lvl   = idle_lvl;
      r.clk_out = clk_lvl;
    end
    r.position_step = held;
    return r;
  endfunction

  // follow register writes, predict on input words, check result words
  always @(posedge clk) begin
    if (rst) begin
      cur = '{ClockModeRst, HalfPeriodRst, TotalBitsRst, SingleBitsRst, IgnoreMtRst};
      tick_cnt = '0;
      half_cnt = '0;
      shreg    = '0;
      running  = 1'b0;
      held     = '0;
      clk_lvl  = 1'b1;
      tick_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegClockMode:  cur.clock_mode        = cfg_data[1:0];
          RegHalfPeriod: cur.half_period_ticks = cfg_data;
          RegTotalBits:  cur.total_bits        = cfg_data[4:0];
          RegSingleBits: cur.single_turn_bits  = cfg_data[4:0];
          RegIgnoreMt:   cur.single_turn_only  = cfg_data[0];
          default: ;
        endcase
      end
      // compare before queuing, a word never comes out in the cycle it goes in
      if (out_valid && out_ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result word with no prediction pending");
          err_cnt++;
        end else begin
          want = tick_results_q.pop_front();
          if (out_item.clk_out !== want.clk_out) begin
            $error("clk_out: expected %0d, got %0d", want.clk_out, out_item.clk_out);
            err_cnt++;
          end
          if (out_item.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, out_item.busy_res);
            err_cnt++;
          end
          if (out_item.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0d, got %0d", want.frame_done,
                   out_item.frame_done);
            err_cnt++;
          end
          if (out_item.position_step !== want.position_step) begin
            $error("position_step: expected 0x%06h, got 0x%06h", want.position_step,
                   out_item.position_step);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) tick_results_q.push_back(clock_one_tick(in_item));
    end
    errors  <= err_cnt;
    pending <= tick_results_q.size();
  end

endmodule

>>> bench/ssi_encoder_frame_reader_core_tb.sv
// ----------------------------------------------------------------------------
// ssi_encoder_frame_reader_core_tb: testbench for the ssi encoder master core
// Feeds tick words (start request, data line) under a series of register
// settings, including mid-frame changes, with random gaps and back pressure.
// A separate checker predicts every result word; this top gives the verdict.
// ----------------------------------------------------------------------------
module ssi_encoder_frame_reader_core_tb;
  import ssi_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = RegClockMode;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;

  int errors;
  int pending;
  int ticks_sent = 0;
  int gap_pct = 15;
  int quiet_cnt = 0;
  bit calm = 1'b0;
  bit want_hold = 1'b0;

  ssi_encoder_frame_reader_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  ssi_frame_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= StallLimit) begin
      $display("ssi_encoder_frame_reader_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // result side: random ready bursts, one long hold on request
  initial begin
    int  run;
    logic rdy;
    run = 0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        run = 0;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        if (run == 0) begin
          rdy = ($urandom_range(0, 2) != 0);
          run = rdy ? $urandom_range(1, 25) : $urandom_range(1, 9);
          out_ready <= rdy;
        end
        run--;
      end
    end
  end

  // offer one tick word, with an occasional idle burst ahead of it
  task automatic send_tick(input logic start, input logic data);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      in_item  <= in_item_t'(2'($urandom_range(0, 3)));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{start_req: start, data_in: data};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // wait until every predicted word has come out and the core is quiet
  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= RegClockMode;
    cfg_data  <= 16'(c.clock_mode);
    @(posedge clk);
    cfg_index <= RegHalfPeriod;
    cfg_data  <= c.half_period_ticks;
    @(posedge clk);
    cfg_index <= RegTotalBits;
    cfg_data  <= 16'(c.total_bits);
    @(posedge clk);
    cfg_index <= RegSingleBits;
    cfg_data  <= 16'(c.single_turn_bits);
    @(posedge clk);
    cfg_index <= RegIgnoreMt;
    cfg_data  <= 16'(c.single_turn_only);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one setting, then a run of ticks; a frame may still be running at the end
  task automatic run_phase(input cfg_t c, input bit wr, input int ticks,
                           input int start_pct, input int one_pct);
    settle();
    if (wr) load_setting(c);
    for (int i = 0; i < ticks; i++)
      send_tick($urandom_range(0, 99) < start_pct, $urandom_range(0, 99) < one_pct);
    in_valid <= 1'b0;
  endtask

  initial begin
    cfg_t c;
    int   r;
    int   n_phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setting: mode 3, long half period, frame left running
    c = '0;
    run_phase(c, 1'b0, 30, 20, 50);
    // one-bit frames at the shortest half period, start held high through busy and done ticks
    run_phase(cfg_t'{2'd0, 16'd1, 5'd1, 5'd1, 1'b0}, 1'b1, 20, 100, 50);
    // zero half period, zero length, zero single-turn bits
    run_phase(cfg_t'{2'd1, 16'd0, 5'd0, 5'd0, 1'b1}, 1'b1, 12, 100, 50);
    // oversized length saturates, mask leaves nothing
    run_phase(cfg_t'{2'd2, 16'd2, 5'd31, 5'd0, 1'b1}, 1'b1, 100, 100, 100);
    // longest frame with all ones on the data line
    run_phase(cfg_t'{2'd3, 16'd1, 5'd23, 5'd23, 1'b0}, 1'b1, 60, 100, 100);
    run_phase(cfg_t'{2'd0, 16'd1, 5'd23, 5'd31, 1'b1}, 1'b1, 60, 100, 0);
    // widest half period, then shortened mid frame
    run_phase(cfg_t'{2'd1, 16'hFFFF, 5'd23, 5'd12, 1'b1}, 1'b1, 25, 100, 50);
    run_phase(cfg_t'{2'd2, 16'd1, 5'd23, 5'd12, 1'b1}, 1'b1, 20, 0, 50);
    // length cut below the bits already clocked
    run_phase(cfg_t'{2'd3, 16'd2, 5'd3, 5'd2, 1'b1}, 1'b1, 20, 0, 50);

    // random settings, mostly clean start-and-read sequences
    n_phase = 0;
    while (ticks_sent < 1200) begin
      c.clock_mode = 2'($urandom_range(0, 3));
      r = $urandom_range(0, 19);
      if (r == 0)      c.half_period_ticks = 16'd0;
      else if (r == 1) c.half_period_ticks = 16'hFFFF;
      else if (r == 2) c.half_period_ticks = 16'($urandom_range(4, 40));
      else             c.half_period_ticks = 16'($urandom_range(1, 3));
      r = $urandom_range(0, 9);
      if (r == 0)      c.total_bits = 5'($urandom_range(24, 31));
      else if (r == 1) c.total_bits = 5'd0;
      else             c.total_bits = 5'($urandom_range(1, 23));
      c.single_turn_bits = 5'($urandom_range(0, 31));
      c.single_turn_only = 1'($urandom_range(0, 1));
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
      // back pressure: the result side holds off while ticks keep coming
      if (n_phase == 3) begin
        gap_pct   = 0;
        want_hold = 1'b1;
      end
      r = $urandom_range(0, 9);
      run_phase(c, 1'b1, $urandom_range(30, 160),
                (r == 0) ? 100 : (r == 1) ? 3 : 40, $urandom_range(0, 100));
      n_phase++;
    end

    // closing stretch without idling
    calm    = 1'b1;
    gap_pct = 0;
    run_phase(cfg_t'{2'd1, 16'd1, 5'd9, 5'd4, 1'b1}, 1'b1, 200, 40, 50);

    settle();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ssi_encoder_frame_reader_core_tb: done, clean");
    end else begin
      $display("ssi_encoder_frame_reader_core_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ssi_pkg.sv
rtl/ssi_cfg_regs.sv
rtl/ssi_frame_step.sv
rtl/ssi_encoder_frame_reader_core.sv
bench/ssi_frame_checker.sv
bench/ssi_encoder_frame_reader_core_tb.sv
